// File: sv/tbpf_pkg.sv
// shared types, constants and helpers for the tiled background pixel fetch
package tbpf_pkg;

	localparam int DATA_W      = 16;
	localparam int CFG_W       = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_BG      = 4;
	localparam int BG_SEL_W    = 2;
	localparam int POS_W       = 8;
	localparam int VIDEO_DEPTH = 49152;
	localparam int VIDEO_AW    = 16;
	localparam int PAL_DEPTH   = 256;
	localparam int PAL_AW      = 8;
	localparam int QUEUE_DEPTH = 2;

	// func codes of an input beat
	localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
	localparam logic [1:0] FUNC_VIDEO_WR = 2'd1;
	localparam logic [1:0] FUNC_PAL_WR   = 2'd2;
	localparam logic [1:0] FUNC_NONE     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BG0_CONTROL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG1_CONTROL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG2_CONTROL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BG3_CONTROL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BG0_OFFSET  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG1_OFFSET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BG2_OFFSET  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BG3_OFFSET  = 3'd7;

	// control word fields
	localparam int CTRL_DEEP_BIT = 7;
	localparam int CTRL_WIDE_BIT = 14;
	localparam int CTRL_TALL_BIT = 15;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_VIDEO_WR,
		OP_PAL_WR
	} op_t;

	// one queued operation, front to back
	typedef struct packed {
		op_t               op;
		logic [1:0]        prio;
		logic              deep;
		logic [1:0]        char_base;
		logic [2:0]        sub_x;
		logic [2:0]        sub_y;
		logic [15:0]       addr;   // map halfword address, or write address
		logic [DATA_W-1:0] data;
	} item_t;

	// halfword addresses past the 96 KB window fold down by 16 K halfwords
	function automatic logic [VIDEO_AW-1:0] fold_half(input logic [VIDEO_AW-1:0] h);
		logic [VIDEO_AW-1:0] r;
		r = h;
		if (h[15] && h[14]) begin
			r[14] = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: sv/tiled_background_pixel_fetch_top.sv
// top level of the tiled background pixel fetch
//
// Takes one beat per cycle, sustained, while no result is held at the
// output, and returns one result beat for each sample beat; video and
// palette writes return nothing. The map read of a sample is taken as its
// beat leaves the two-entry queue, then come the texel read and the
// palette read, all registered memory reads. The rate is set by the back
// pipeline, where the video memory is read twice per item (map entry and
// texel) from two mirrored copies, so both reads proceed in the same cycle
// for neighboring items. A held result stops the back pipe; the queue then
// fills and in_ready drops after one more beat when beats stream back to
// back, or two when the queue was empty. Video writes take effect
// in order with samples: a sample accepted after a write sees it. Video and
// palette contents are undefined until written; there is no clearing pass.
// Configuration writes take effect at once and belong in idle periods.
module tiled_background_pixel_fetch_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [tbpf_pkg::BG_SEL_W-1:0]   bg_select,
	input  logic [15:0]                     mem_address,
	input  logic [tbpf_pkg::DATA_W-1:0]     write_data,
	input  logic [tbpf_pkg::POS_W-1:0]      line,
	input  logic [tbpf_pkg::POS_W-1:0]      column,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tbpf_pkg::DATA_W-1:0]     color,
	output logic                            opaque,
	output logic [1:0]                      priority_res
);

	// front to queue
	logic            push_valid;
	tbpf_pkg::item_t push_item;
	logic            q_full;

	// queue to back
	logic            q_valid;
	logic            q_ready;
	tbpf_pkg::item_t q_item;

	// input ready only depends on queue space, never on the output side
	assign in_ready = !q_full;

	tbpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.bg_select   (bg_select),
		.mem_address (mem_address),
		.write_data  (write_data),
		.line        (line),
		.column      (column),
		.push_valid  (push_valid),
		.push_item   (push_item)
	);

	tbpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	tbpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_ready      (q_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.color        (color),
		.opaque       (opaque),
		.priority_res (priority_res)
	);

	// a full queue is never empty
	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("queue full but reports no data");

	// a held result must freeze the back pipe
	a_stall_holds_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !q_ready)
		else $error("back pipe advanced under a held result");

	// transparent pixels carry no color and no priority
	a_transparent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !opaque) |-> (color == '0 && priority_res == 2'b0))
		else $error("transparent beat with color or priority");

	// the front only pushes beats that were accepted
	a_push_is_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (in_valid && in_ready))
		else $error("queue push without an accepted beat");

endmodule

// File: sv/tbpf_ram.sv
// generic single write, single registered read memory
module tbpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/tbpf_front.sv
// front part: config registers, beat classification and map address
module tbpf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [tbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [tbpf_pkg::BG_SEL_W-1:0]   bg_select,
	input  logic [15:0]                     mem_address,
	input  logic [tbpf_pkg::DATA_W-1:0]     write_data,
	input  logic [tbpf_pkg::POS_W-1:0]      line,
	input  logic [tbpf_pkg::POS_W-1:0]      column,
	output logic                            push_valid,
	output tbpf_pkg::item_t                 push_item
);

	logic [15:0] bg_control_q [tbpf_pkg::NUM_BG];
	logic [17:0] bg_offset_q  [tbpf_pkg::NUM_BG];

	logic [15:0] ctrl;
	logic [17:0] ofs;
	logic        wide;
	logic        tall;
	logic [8:0]  px_sum;
	logic [8:0]  py_sum;
	logic [8:0]  px;
	logic [8:0]  py;
	logic [1:0]  block;
	logic [5:0]  map_blk;
	logic [15:0] map_half;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbpf_pkg::NUM_BG; i++) begin
				bg_control_q[i] <= '0;
				bg_offset_q[i]  <= '0;
			end
		end else if (cfg_write) begin
			unique case (cfg_index)
				tbpf_pkg::REG_BG0_CONTROL: bg_control_q[0] <= cfg_data[15:0];
				tbpf_pkg::REG_BG1_CONTROL: bg_control_q[1] <= cfg_data[15:0];
				tbpf_pkg::REG_BG2_CONTROL: bg_control_q[2] <= cfg_data[15:0];
				tbpf_pkg::REG_BG3_CONTROL: bg_control_q[3] <= cfg_data[15:0];
				tbpf_pkg::REG_BG0_OFFSET:  bg_offset_q[0]  <= cfg_data;
				tbpf_pkg::REG_BG1_OFFSET:  bg_offset_q[1]  <= cfg_data;
				tbpf_pkg::REG_BG2_OFFSET:  bg_offset_q[2]  <= cfg_data;
				tbpf_pkg::REG_BG3_OFFSET:  bg_offset_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// scroll, wrap to map size, locate the screen block entry
	always_comb begin
		ctrl     = bg_control_q[bg_select];
		ofs      = bg_offset_q[bg_select];
		wide     = ctrl[tbpf_pkg::CTRL_WIDE_BIT];
		tall     = ctrl[tbpf_pkg::CTRL_TALL_BIT];
		px_sum   = {1'b0, column} + ofs[8:0];
		py_sum   = {1'b0, line} + ofs[17:9];
		px       = {px_sum[8] & wide, px_sum[7:0]};
		py       = {py_sum[8] & tall, py_sum[7:0]};
		block    = {1'b0, px[8]} + (wide ? {py[8], 1'b0} : {1'b0, py[8]});
		map_blk  = {1'b0, ctrl[12:8]} + {4'b0, block};
		map_half = {map_blk, py[7:3], px[7:3]};
	end

	always_comb begin
		take                = in_valid && in_ready;
		push_valid          = 1'b0;
		push_item.op        = tbpf_pkg::OP_SAMPLE;
		push_item.prio      = ctrl[1:0];
		push_item.deep      = ctrl[tbpf_pkg::CTRL_DEEP_BIT];
		push_item.char_base = ctrl[3:2];
		push_item.sub_x     = px[2:0];
		push_item.sub_y     = py[2:0];
		push_item.addr      = tbpf_pkg::fold_half(map_half);
		push_item.data      = write_data;
		unique case (func)
			tbpf_pkg::FUNC_SAMPLE: begin
				push_valid = take;
			end
			tbpf_pkg::FUNC_VIDEO_WR: begin
				push_item.op   = tbpf_pkg::OP_VIDEO_WR;
				push_item.addr = mem_address;
				// writes past the end of video memory are dropped
				push_valid     = take && (mem_address < 16'(tbpf_pkg::VIDEO_DEPTH));
			end
			tbpf_pkg::FUNC_PAL_WR: begin
				push_item.op   = tbpf_pkg::OP_PAL_WR;
				push_item.addr = {8'b0, mem_address[7:0]};
				push_valid     = take;
			end
			tbpf_pkg::FUNC_NONE: begin
				push_valid = 1'b0;
			end
		endcase
	end

endmodule

// File: sv/tbpf_queue.sv
// short queue between front and back
module tbpf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  tbpf_pkg::item_t push_item,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tbpf_pkg::item_t pop_item
);

	localparam int PW = $clog2(tbpf_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(tbpf_pkg::QUEUE_DEPTH + 1);

	tbpf_pkg::item_t slot_q [tbpf_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(tbpf_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: sv/tbpf_back.sv
// back part: map read, texel read, palette read
module tbpf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  tbpf_pkg::item_t             q_item,
	output logic                        q_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tbpf_pkg::DATA_W-1:0] color,
	output logic                        opaque,
	output logic [1:0]                  priority_res
);

	logic adv;
	logic pop;
	logic vid_we;

	logic                          valid_s1;
	tbpf_pkg::item_t               item_s1;
	logic [tbpf_pkg::DATA_W-1:0]   map_rdata;
	logic [2:0]                    sx;
	logic [2:0]                    sy;
	logic [15:0]                   tile_off;
	logic [16:0]                   tex_byte;
	logic [tbpf_pkg::VIDEO_AW-1:0] tex_half;

	logic                          valid_s2;
	tbpf_pkg::op_t                 op_s2;
	logic [1:0]                    prio_s2;
	logic                          deep_s2;
	logic [3:0]                    bank_s2;
	logic                          nib_s2;
	logic                          bsel_s2;
	logic [tbpf_pkg::PAL_AW-1:0]   pal_addr_s2;
	logic [tbpf_pkg::DATA_W-1:0]   pal_data_s2;
	logic [tbpf_pkg::DATA_W-1:0]   tex_rdata;
	logic [7:0]                    tex_val;
	logic [3:0]                    nibble;
	logic                          idx_nz;
	logic [tbpf_pkg::PAL_AW-1:0]   pal_idx;
	logic                          pal_we;

	logic                          valid_s3;
	tbpf_pkg::op_t                 op_s3;
	logic                          opaque_s3;
	logic [1:0]                    prio_s3;
	logic [tbpf_pkg::DATA_W-1:0]   pal_rdata;

	// the whole pipe moves together unless a result is held at the output
	assign adv     = !(out_valid && !out_ready);
	assign q_ready = adv;
	assign pop     = adv && q_valid;
	assign vid_we  = pop && (q_item.op == tbpf_pkg::OP_VIDEO_WR);

	// two identical video copies give the map and texel read ports
	tbpf_ram #(.WIDTH(tbpf_pkg::DATA_W), .DEPTH(tbpf_pkg::VIDEO_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (vid_we),
		.waddr (q_item.addr),
		.wdata (q_item.data),
		.re    (adv),
		.raddr (q_item.addr),
		.rdata (map_rdata)
	);

	tbpf_ram #(.WIDTH(tbpf_pkg::DATA_W), .DEPTH(tbpf_pkg::VIDEO_DEPTH)) u_tex_ram (
		.clk   (clk),
		.we    (vid_we),
		.waddr (q_item.addr),
		.wdata (q_item.data),
		.re    (adv),
		.raddr (tex_half),
		.rdata (tex_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: map entry in hand, flip and form the texel address
	always_comb begin
		sx = map_rdata[10] ? ~item_s1.sub_x : item_s1.sub_x;
		sy = map_rdata[11] ? ~item_s1.sub_y : item_s1.sub_y;
		if (item_s1.deep) begin
			tile_off = {map_rdata[9:0], sy, sx};
		end else begin
			tile_off = {1'b0, map_rdata[9:0], sy, sx[2:1]};
		end
		tex_byte = {1'b0, item_s1.char_base, 14'b0} + {1'b0, tile_off};
		tex_half = tbpf_pkg::fold_half(tex_byte[16:1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1     <= q_item;
			op_s2       <= item_s1.op;
			prio_s2     <= item_s1.prio;
			deep_s2     <= item_s1.deep;
			bank_s2     <= map_rdata[15:12];
			nib_s2      <= sx[0];
			bsel_s2     <= tex_byte[0];
			pal_addr_s2 <= item_s1.addr[7:0];
			pal_data_s2 <= item_s1.data;
			op_s3       <= op_s2;
			opaque_s3   <= idx_nz;
			prio_s3     <= prio_s2;
		end
	end

	// stage 2: texel in hand, pick the palette index
	always_comb begin
		tex_val = bsel_s2 ? tex_rdata[15:8] : tex_rdata[7:0];
		nibble  = nib_s2 ? tex_val[7:4] : tex_val[3:0];
		idx_nz  = deep_s2 ? (tex_val != '0) : (nibble != '0);
		pal_idx = deep_s2 ? tex_val : {bank_s2, nibble};
		pal_we  = adv && valid_s2 && (op_s2 == tbpf_pkg::OP_PAL_WR);
	end

	// palette writes happen here so they stay in order with palette reads
	tbpf_ram #(.WIDTH(tbpf_pkg::DATA_W), .DEPTH(tbpf_pkg::PAL_DEPTH)) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_addr_s2),
		.wdata (pal_data_s2),
		.re    (adv),
		.raddr (pal_idx),
		.rdata (pal_rdata)
	);

	// stage 3: result
	assign out_valid    = valid_s3 && (op_s3 == tbpf_pkg::OP_SAMPLE);
	assign color        = opaque_s3 ? pal_rdata : '0;
	assign opaque       = opaque_s3;
	assign priority_res = opaque_s3 ? prio_s3 : 2'b0;

endmodule

// File: sim/tbpf_scoreboard_pkg.sv
`timescale 1ns / 1ps
// beat types and the pixel scoreboard with its own copy of video, palette and registers
package tbpf_scoreboard_pkg;
	import tbpf_pkg::*;

	typedef struct packed {
		logic [1:0]        func;
		logic [1:0]        bg;
		logic [15:0]       addr;
		logic [DATA_W-1:0] data;
		logic [7:0]        line;
		logic [7:0]        col;
	} fetch_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] color;
		logic              opaque;
		logic [1:0]        prio;
	} pixel_t;

	class pixel_scoreboard;
		logic [DATA_W-1:0] video_copy [VIDEO_DEPTH];
		logic [DATA_W-1:0] palette_copy [PAL_DEPTH];
		bit                video_known [VIDEO_DEPTH];
		bit                palette_known [PAL_DEPTH];
		logic [15:0]       bg_ctrl [NUM_BG];
		logic [17:0]       bg_scroll [NUM_BG];
		pixel_t            pending_pixels [$];
		int                error_count;
		int                results_seen;

		function new();
			error_count  = 0;
			results_seen = 0;
			foreach (bg_ctrl[i]) begin
				bg_ctrl[i]   = '0;
				bg_scroll[i] = '0;
			end
		endfunction

		// byte address wraps at 128 KB, top 32 KB mirrors down
		function int unsigned fold_byte(input int unsigned byte_addr);
			int unsigned m;
			m = byte_addr & 32'h1FFFF;
			if (m >= 32'h18000) begin
				m -= 32'h8000;
			end
			return m;
		endfunction

		function logic [7:0] video_byte(input int unsigned byte_addr);
			int unsigned m;
			logic [15:0] h;
			m = fold_byte(byte_addr);
			h = video_copy[m >> 1];
			return ((m & 32'd1) != 0) ? h[15:8] : h[7:0];
		endfunction

		// map and texel halfwords a sample reads, its palette index and whether it is lit
		function void locate(input logic [1:0] bg, input logic [7:0] y,
				input logic [7:0] x, output int unsigned map_h, output int unsigned tex_h,
				output logic [7:0] pal_index, output bit lit);
			logic [15:0] ctrl;
			logic [17:0] scroll;
			int unsigned wrap_x, wrap_y, px, py, tx, ty, blk, entry_addr, char_base;
			int unsigned tex_addr;
			logic [15:0] entry;
			logic [2:0]  sx, sy;
			logic [7:0]  texel, idx;
			ctrl   = bg_ctrl[bg];
			scroll = bg_scroll[bg];
			wrap_x = ctrl[CTRL_WIDE_BIT] ? 32'h1FF : 32'hFF;
			wrap_y = ctrl[CTRL_TALL_BIT] ? 32'h1FF : 32'hFF;
			px = (32'(x) + 32'(scroll[8:0])) & wrap_x;
			py = (32'(y) + 32'(scroll[17:9])) & wrap_y;
			tx = px >> 3;
			ty = py >> 3;
			blk = (tx >> 5) + (ty >> 5) * (ctrl[CTRL_WIDE_BIT] ? 32'd2 : 32'd1);
			entry_addr = (32'(ctrl[12:8]) + blk) * 32'h800
				+ ((ty & 32'd31) * 32'd32 + (tx & 32'd31)) * 32'd2;
			map_h = fold_byte(entry_addr) >> 1;
			entry = video_copy[map_h];
			sx = 3'(px);
			sy = 3'(py);
			if (entry[10]) begin
				sx = 3'd7 - sx;
			end
			if (entry[11]) begin
				sy = 3'd7 - sy;
			end
			char_base = 32'(ctrl[3:2]) * 32'h4000;
			if (!ctrl[CTRL_DEEP_BIT]) begin
				tex_addr = char_base + 32'(entry[9:0]) * 32'd32 + 32'(sy) * 32'd4
					+ 32'(sx >> 1);
				texel = video_byte(tex_addr);
				idx = sx[0] ? {4'h0, texel[7:4]} : {4'h0, texel[3:0]};
				pal_index = {entry[15:12], idx[3:0]};
			end else begin
				tex_addr = char_base + 32'(entry[9:0]) * 32'd64 + 32'(sy) * 32'd8
					+ 32'(sx);
				idx = video_byte(tex_addr);
				pal_index = idx;
			end
			tex_h = fold_byte(tex_addr) >> 1;
			lit = (idx != 8'd0);
		endfunction

		function pixel_t predict_pixel(input logic [1:0] bg, input logic [7:0] y,
				input logic [7:0] x);
			int unsigned map_h, tex_h;
			logic [7:0]  pal_index;
			bit          lit;
			pixel_t      p;
			locate(bg, y, x, map_h, tex_h, pal_index, lit);
			p = '0;
			if (lit) begin
				p.color  = palette_copy[pal_index];
				p.opaque = 1'b1;
				p.prio   = bg_ctrl[bg][1:0];
			end
			return p;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] index,
				input logic [CFG_W-1:0] value);
			if (index < REG_BG0_OFFSET) begin
				bg_ctrl[index[1:0]] = value[15:0];
			end else begin
				bg_scroll[index[1:0]] = value;
			end
		endfunction

		function void note_beat(input fetch_beat_t b);
			case (b.func)
				FUNC_SAMPLE: begin
					pending_pixels.push_back(predict_pixel(b.bg, b.line, b.col));
				end
				FUNC_VIDEO_WR: begin
					if (32'(b.addr) < VIDEO_DEPTH) begin
						video_copy[b.addr]  = b.data;
						video_known[b.addr] = 1'b1;
					end
				end
				FUNC_PAL_WR: begin
					palette_copy[b.addr[7:0]]  = b.data;
					palette_known[b.addr[7:0]] = 1'b1;
				end
				default: begin
				end
			endcase
		endfunction

		function int outstanding();
			return pending_pixels.size();
		endfunction

		task flag_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			error_count++;
		endtask

		task check_pixel(input logic [DATA_W-1:0] color, input logic opaque,
				input logic [1:0] prio);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				flag_mismatch($sformatf("pixel %0d arrived with none pending", results_seen));
			end else begin
				want = pending_pixels.pop_front();
				if (color !== want.color) begin
					flag_mismatch($sformatf("pixel %0d color got %h want %h",
						results_seen, color, want.color));
				end
				if (opaque !== want.opaque) begin
					flag_mismatch($sformatf("pixel %0d opaque got %b want %b",
						results_seen, opaque, want.opaque));
				end
				if (prio !== want.prio) begin
					flag_mismatch($sformatf("pixel %0d priority got %0d want %0d",
						results_seen, prio, want.prio));
				end
			end
			results_seen++;
		endtask
	endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// top of the pixel fetch testbench: clock, reset, drivers, result monitor and watchdog
module tb_top;
	import tbpf_pkg::*;
	import tbpf_scoreboard_pkg::*;

	localparam int IDLE_MAX         = 14;
	localparam int HOLD_OFF_CYCLES  = 150;  // long receiver stall, fills the queue
	localparam int SETTLE_CYCLES    = 8;    // queue plus three read stages, with margin
	localparam int WATCHDOG_LIMIT   = 1000; // well above hold-off plus worst gaps
	localparam int NUM_PHASES       = 6;
	localparam int CHUNKS_PER_PHASE = 5;
	localparam int CHUNK_BEATS      = 19;

	typedef enum {SET_ZERO, SET_MAX, SET_RANDOM} bg_setting_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_W-1:0]      cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [1:0]            func         = FUNC_SAMPLE;
	logic [BG_SEL_W-1:0]   bg_select    = '0;
	logic [15:0]           mem_address  = '0;
	logic [DATA_W-1:0]     write_data   = '0;
	logic [POS_W-1:0]      line         = '0;
	logic [POS_W-1:0]      column       = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [DATA_W-1:0]     color;
	logic                  opaque;
	logic [1:0]            priority_res;

	pixel_scoreboard board;

	// idle behavior per stretch of stimulus, set by the stimulus process
	bit tx_idle      = 1'b0;
	bit rx_idle      = 1'b0;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	tiled_background_pixel_fetch_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.bg_select    (bg_select),
		.mem_address  (mem_address),
		.write_data   (write_data),
		.line         (line),
		.column       (column),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.color        (color),
		.opaque       (opaque),
		.priority_res (priority_res)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic fetch_beat_t make_beat(input logic [1:0] f, input logic [1:0] bg,
			input logic [15:0] addr, input logic [15:0] data, input logic [7:0] y,
			input logic [7:0] x);
		fetch_beat_t b;
		b.func = f;
		b.bg   = bg;
		b.addr = addr;
		b.data = data;
		b.line = y;
		b.col  = x;
		return b;
	endfunction

	// mostly random words, one in eight zero so transparent texels show up often
	function automatic logic [15:0] seed_word();
		return ($urandom_range(7, 0) == 0) ? 16'h0000 : 16'($urandom);
	endfunction

	function automatic fetch_beat_t random_beat();
		fetch_beat_t b;
		int unsigned roll;
		roll = $urandom_range(99, 0);
		b = make_beat(FUNC_SAMPLE, 2'($urandom_range(3, 0)), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom));
		if (roll < 55) begin
			// samples: mostly on screen, the rest anywhere in the 8-bit range
			if ($urandom_range(4, 0) != 0) begin
				b.line = 8'($urandom_range(159, 0));
				b.col  = 8'($urandom_range(239, 0));
			end
		end else if (roll < 80) begin
			// video writes, a few past the end of memory which must be dropped
			b.func = FUNC_VIDEO_WR;
			if ($urandom_range(15, 0) == 0) begin
				b.addr = 16'($urandom_range(65535, VIDEO_DEPTH));
			end else begin
				b.addr = 16'($urandom_range(VIDEO_DEPTH - 1, 0));
			end
			b.data = seed_word();
		end else if (roll < 93) begin
			b.func = FUNC_PAL_WR;
		end else begin
			b.func = FUNC_NONE;
		end
		return b;
	endfunction

	// one input beat: optional gap, then hold valid and payload until accepted
	task automatic drive_beat(input fetch_beat_t b);
		int gap;
		gap = tx_idle ? $urandom_range(IDLE_MAX, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= b.func;
		bg_select   <= b.bg;
		mem_address <= b.addr;
		write_data  <= b.data;
		line        <= b.line;
		column      <= b.col;
		// in_ready read here is its value just before this edge
		do @(posedge clk); while (!in_ready);
		board.note_beat(b);
	endtask

	// memories are undefined until written: before a sample, write the map
	// entry, the texel halfword and the palette entry it reads if still unwritten
	task automatic prime_sample(input fetch_beat_t b);
		int unsigned map_h, tex_h;
		logic [7:0]  pal_index;
		bit          lit;
		board.locate(b.bg, b.line, b.col, map_h, tex_h, pal_index, lit);
		if (!board.video_known[map_h]) begin
			drive_beat(make_beat(FUNC_VIDEO_WR, b.bg, 16'(map_h), seed_word(),
				b.line, b.col));
		end
		board.locate(b.bg, b.line, b.col, map_h, tex_h, pal_index, lit);
		if (!board.video_known[tex_h]) begin
			drive_beat(make_beat(FUNC_VIDEO_WR, b.bg, 16'(tex_h), seed_word(),
				b.line, b.col));
		end
		board.locate(b.bg, b.line, b.col, map_h, tex_h, pal_index, lit);
		if (lit && !board.palette_known[pal_index]) begin
			drive_beat(make_beat(FUNC_PAL_WR, b.bg, {8'($urandom), pal_index},
				16'($urandom), b.line, b.col));
		end
	endtask

	task automatic send_beat(input fetch_beat_t b);
		if (b.func == FUNC_SAMPLE) begin
			prime_sample(b);
		end
		drive_beat(b);
	endtask

	// stop offering beats, wait out every pending pixel, then let writes settle
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all eight registers, one per cycle, only while the block is idle
	task automatic program_backgrounds(input bg_setting_t setting);
		int i;
		logic [CFG_W-1:0] value;
		for (i = REG_BG0_CONTROL; i <= REG_BG3_OFFSET; i++) begin
			case (setting)
				SET_ZERO: value = '0;
				SET_MAX:  value = (i < REG_BG0_OFFSET) ? 18'h0FFFF : 18'h3FFFF;
				default: begin
					if (i < REG_BG0_OFFSET) begin
						value = 18'($urandom_range(65535, 0));
					end else begin
						value = 18'($urandom_range(262143, 0));
					end
				end
			endcase
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= value;
			@(posedge clk);
			board.write_reg(CFG_IDX_W'(i), value);
		end
		cfg_write <= 1'b0;
	endtask

	// result side: random stall per pixel, or one long hold-off when asked
	initial begin : result_sink
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				stall = HOLD_OFF_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = rx_idle ? $urandom_range(IDLE_MAX, 0) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// every accepted pixel is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_pixel(color, opaque, priority_res);
		end
	end

	// gives up when neither channel moves a beat for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tiled_background_pixel_fetch_top verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, chunk;
		logic [1:0] mix;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_backgrounds(SET_ZERO);

		// directed part, all backgrounds at reset settings (4bpp, 256x256, bases 0)
		// map entry zero doubles as the first four texels of tile zero: transparent
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'h0000, 16'h0000, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd0, 16'h0000, 16'h0000, 8'd0, 8'd0));
		// both flips, palette bank 15: corner pixel reads the last byte of tile zero
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'h0000, 16'hFC00, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'h000F, 16'hF123, 8'd0, 8'd0));
		// palette index comes from the low address byte only
		send_beat(make_beat(FUNC_PAL_WR, 2'd3, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd0, 16'h0000, 16'h0000, 8'd0, 8'd0));
		// writes past the end of video memory must change nothing
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'hC000, 16'h0000, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'hFFFF, 16'h0000, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd0, 16'h0000, 16'h0000, 8'd0, 8'd0));
		// horizontal flip only
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'h0000, 16'h0400, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd1, 16'h0000, 16'h0000, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_VIDEO_WR, 2'd0, 16'hBFFF, 16'hA5A5, 8'd0, 8'd0));
		// unused function code gives no pixel
		send_beat(make_beat(FUNC_NONE, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		send_beat(make_beat(FUNC_SAMPLE, 2'd2, 16'h0000, 16'h0000, 8'd159, 8'd239));
		// positions past the screen wrap with the map
		send_beat(make_beat(FUNC_SAMPLE, 2'd3, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255));
		send_beat(make_beat(FUNC_PAL_WR, 2'd0, 16'h1200, 16'h0000, 8'd0, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd0, 16'h0000, 16'h0000, 8'd255, 8'd0));
		send_beat(make_beat(FUNC_SAMPLE, 2'd0, 16'h0000, 16'h0000, 8'd0, 8'd255));
		send_beat(make_beat(FUNC_SAMPLE, 2'd1, 16'h0000, 16'h0000, 8'd7, 8'd7));

		// random phases: reset values, all ones (deep, far bases, largest map,
		// mirrored fetches), then random settings
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 1) begin
				drain_pipe();
				program_backgrounds(SET_MAX);
			end else if (phase > 1) begin
				drain_pipe();
				program_backgrounds(SET_RANDOM);
			end
			for (chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
				mix = 2'($urandom_range(3, 0));
				tx_idle = mix[0];
				rx_idle = mix[1];
				// back pressure: steady sender against a long receiver stall
				if (phase > 0 && chunk == 0) begin
					tx_idle = 1'b0;
					rx_idle = 1'b0;
					hold_request = 1'b1;
				end
				repeat (CHUNK_BEATS) send_beat(random_beat());
			end
		end

		drain_pipe();
		if (board.error_count == 0) begin
			$display("tiled_background_pixel_fetch_top verification clean");
		end else begin
			$display("tiled_background_pixel_fetch_top verification failed");
		end
		$finish;
	end

endmodule
